FILE: rtl/spng_pkg.sv
// Package for the spectral peak noise gate: field widths, register codes,
// reset values and result status codes. No dependencies.
package spng_pkg;

    localparam int PWR_W      = 48;  // bin power, saturating
    localparam int TOT_W      = 57;  // running power total, saturating
    localparam int PEAK_W     = 9;   // reported peak bin index
    localparam int FBIN_W     = 9;
    localparam int LOG2_W     = 4;
    localparam int RATIO_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int MIN_LOG2   = 5;
    localparam int OUT_TDATA_W = ((PEAK_W + PWR_W + TOT_W + 7) / 8) * 8;

    localparam logic [FBIN_W-1:0]  FIRST_BIN_RST = FBIN_W'(5);
    localparam logic [LOG2_W-1:0]  FFT_LOG2_RST  = LOG2_W'(10);
    localparam logic [PWR_W-1:0]   PWR_THR_RST   = '0;
    localparam logic [RATIO_W-1:0] RATIO_RST     = RATIO_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_BIN = 2'd0,
        CFG_FFT_LOG2  = 2'd1,
        CFG_PWR_THR   = 2'd2,
        CFG_RATIO     = 2'd3
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        ST_DETECTED  = 2'd0,
        ST_TOO_FEW   = 2'd1,
        ST_BELOW_THR = 2'd2,
        ST_RATIO_LOW = 2'd3
    } t_status;

endpackage

FILE: rtl/spectral_peak_noise_gate_unit.sv
// Spectral peak noise gate, top level: per-bin power, peak search and
// frame-end detection decision. Depends on spng_pkg.
//
// The block takes one complex FFT bin per word on the slave stream, with
// tlast on the final bin of a frame, and returns one result word per frame
// on the master stream. Bins are numbered from 0 in each frame; a bin is
// analyzed when first_bin <= index < FFT length / 2. For each analyzed bin
// the power re^2 + im^2 (saturated to 48 bits) is added to a saturating
// 57-bit total, and the first strictly largest bin is kept. At the frame end
// the result gives the peak bin, its power, the noise sum (total minus peak)
// and a status: too few bins when at most one bin was analyzed, below
// threshold when the peak power is under power_threshold, ratio too low when
// peak*(count-1)*256 < noise*ratio_q8, otherwise detected. The block accepts
// one word every cycle while the pipeline is not stalled; a frame result
// passes through a pipeline of input register, squarers, accumulator,
// noise and flag stage, product stage and result register. While the result
// register holds a word that is not taken, the whole pipeline stalls and
// tready on the slave side drops. Configuration writes take effect at once
// and are meant to be made while no frame is in flight.
module spectral_peak_noise_gate_unit #(
    parameter int MAX_FFT_SIZE = 1024,
    parameter int BIN_WIDTH    = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [spng_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [spng_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Slave stream: one FFT bin per word.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata, from bit 0: bin_real, bin_imag, zero padding.
    input  logic [((2*BIN_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,   // frame_last
    // Master stream: one result word per frame.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata, from bit 0: peak_bin, peak_power, noise_sum, zero padding.
    output logic [spng_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // tuser: status.
    output logic [spng_pkg::STATUS_W-1:0]       o_m_axis_tuser
);

    localparam int IDX_W   = $clog2(MAX_FFT_SIZE);
    localparam int TOP_LOG2 = $clog2(MAX_FFT_SIZE + 1) - 1;
    localparam int CNT_W   = $clog2(MAX_FFT_SIZE / 2 + 1);
    localparam int SQ_W    = 2 * BIN_WIDTH;
    localparam int PS_W    = SQ_W + 1;
    localparam int SX_W    = (PS_W > spng_pkg::PWR_W + 1) ? PS_W : spng_pkg::PWR_W + 1;
    localparam int CI_W    = (IDX_W > spng_pkg::FBIN_W) ? IDX_W : spng_pkg::FBIN_W;
    localparam int LHS_W   = spng_pkg::PWR_W + CNT_W;
    localparam int RHS_W   = spng_pkg::TOT_W + spng_pkg::RATIO_W;
    localparam int CMP_W   = (LHS_W + 8 > RHS_W) ? LHS_W + 8 : RHS_W;
    localparam int PWR_W   = spng_pkg::PWR_W;
    localparam int TOT_W   = spng_pkg::TOT_W;
    localparam int PEAK_W  = spng_pkg::PEAK_W;
    localparam int PAD_W   = spng_pkg::OUT_TDATA_W - PEAK_W - PWR_W - TOT_W;

    // Configuration registers.
    logic [spng_pkg::FBIN_W-1:0]  r_first_bin;
    logic [spng_pkg::LOG2_W-1:0]  r_fft_log2;
    logic [PWR_W-1:0]             r_pwr_thr;
    logic [spng_pkg::RATIO_W-1:0] r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_bin <= spng_pkg::FIRST_BIN_RST;
            r_fft_log2  <= spng_pkg::FFT_LOG2_RST;
            r_pwr_thr   <= spng_pkg::PWR_THR_RST;
            r_ratio     <= spng_pkg::RATIO_RST;
        end else if (i_cfg_we) begin
            unique case (spng_pkg::t_cfg_reg'(i_cfg_idx))
                spng_pkg::CFG_FIRST_BIN: r_first_bin <= i_cfg_data[spng_pkg::FBIN_W-1:0];
                spng_pkg::CFG_FFT_LOG2:  r_fft_log2  <= i_cfg_data[spng_pkg::LOG2_W-1:0];
                spng_pkg::CFG_PWR_THR:   r_pwr_thr   <= i_cfg_data[PWR_W-1:0];
                spng_pkg::CFG_RATIO:     r_ratio     <= i_cfg_data[spng_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together whenever the result register is
    // empty or being drained.
    logic pipe_en;
    logic s_accept;
    logic r_out_valid;

    assign pipe_en         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = pipe_en;
    assign s_accept        = i_s_axis_tvalid && pipe_en;

    // Stage 0: bin counter and analysis window, input register.
    logic [spng_pkg::LOG2_W-1:0] lg_c;
    logic [IDX_W:0]              half;
    logic                        in_window;
    logic [IDX_W-1:0]            r_bin_idx;

    always_comb begin
        priority if (r_fft_log2 < spng_pkg::LOG2_W'(spng_pkg::MIN_LOG2)) begin
            lg_c = spng_pkg::LOG2_W'(spng_pkg::MIN_LOG2);
        end else if (r_fft_log2 > spng_pkg::LOG2_W'(TOP_LOG2)) begin
            lg_c = spng_pkg::LOG2_W'(TOP_LOG2);
        end else begin
            lg_c = r_fft_log2;
        end
        half      = (IDX_W+1)'(1) << (lg_c - spng_pkg::LOG2_W'(1));
        in_window = (CI_W'(r_bin_idx) >= CI_W'(r_first_bin))
                 && ((IDX_W+1)'(r_bin_idx) < half);
    end

    logic                        r_s0_vld;
    logic                        r_s0_last;
    logic                        r_s0_ana;
    logic [PEAK_W-1:0]           r_s0_idx;
    logic signed [BIN_WIDTH-1:0] r_s0_re;
    logic signed [BIN_WIDTH-1:0] r_s0_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_idx <= '0;
            r_s0_vld  <= 1'b0;
        end else if (pipe_en) begin
            r_s0_vld <= s_accept;
            if (s_accept) begin
                if (i_s_axis_tlast) begin
                    r_bin_idx <= '0;
                end else if (r_bin_idx != IDX_W'(MAX_FFT_SIZE - 1)) begin
                    r_bin_idx <= r_bin_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en && s_accept) begin
            r_s0_last <= i_s_axis_tlast;
            r_s0_ana  <= in_window;
            r_s0_idx  <= PEAK_W'(r_bin_idx);
            r_s0_re   <= i_s_axis_tdata[BIN_WIDTH-1:0];
            r_s0_im   <= i_s_axis_tdata[2*BIN_WIDTH-1:BIN_WIDTH];
        end
    end

    // Stage 1: magnitudes and squares.
    logic [BIN_WIDTH-1:0] abs_re;
    logic [BIN_WIDTH-1:0] abs_im;

    assign abs_re = r_s0_re[BIN_WIDTH-1] ? BIN_WIDTH'(-r_s0_re) : BIN_WIDTH'(r_s0_re);
    assign abs_im = r_s0_im[BIN_WIDTH-1] ? BIN_WIDTH'(-r_s0_im) : BIN_WIDTH'(r_s0_im);

    logic              r_s1_vld;
    logic              r_s1_last;
    logic              r_s1_ana;
    logic [PEAK_W-1:0] r_s1_idx;
    logic [SQ_W-1:0]   r_s1_sq_re;
    logic [SQ_W-1:0]   r_s1_sq_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_last  <= r_s0_last;
            r_s1_ana   <= r_s0_ana;
            r_s1_idx   <= r_s0_idx;
            r_s1_sq_re <= SQ_W'(abs_re) * SQ_W'(abs_re);
            r_s1_sq_im <= SQ_W'(abs_im) * SQ_W'(abs_im);
        end
    end

    // Stage 2: bin power, running total and peak search.
    logic [SX_W-1:0]   pwr_x;
    logic [PWR_W-1:0]  pwr;
    logic [TOT_W:0]    tot_x;
    logic [PWR_W-1:0]  r_max;
    logic [PEAK_W-1:0] r_max_idx;
    logic [TOT_W-1:0]  r_total;
    logic [CNT_W-1:0]  r_cnt;
    logic [PWR_W-1:0]  n_max;
    logic [PEAK_W-1:0] n_max_idx;
    logic [TOT_W-1:0]  n_total;
    logic [CNT_W-1:0]  n_cnt;

    always_comb begin
        pwr_x = SX_W'(r_s1_sq_re) + SX_W'(r_s1_sq_im);
        pwr   = (|pwr_x[SX_W-1:PWR_W]) ? '1 : pwr_x[PWR_W-1:0];
        tot_x = (TOT_W+1)'(r_total) + (TOT_W+1)'(pwr);
        n_max     = r_max;
        n_max_idx = r_max_idx;
        n_total   = r_total;
        n_cnt     = r_cnt;
        if (r_s1_ana) begin
            n_total = tot_x[TOT_W] ? '1 : tot_x[TOT_W-1:0];
            n_cnt   = r_cnt + CNT_W'(1);
            if (pwr > r_max) begin
                n_max     = pwr;
                n_max_idx = r_s1_idx;
            end
        end
    end

    logic              r_s2_vld;
    logic [PWR_W-1:0]  r_s2_max;
    logic [PEAK_W-1:0] r_s2_idx;
    logic [TOT_W-1:0]  r_s2_total;
    logic [CNT_W-1:0]  r_s2_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= '0;
            r_max_idx <= '0;
            r_total   <= '0;
            r_cnt     <= '0;
            r_s2_vld  <= 1'b0;
        end else if (pipe_en) begin
            r_s2_vld <= r_s1_vld && r_s1_last;
            if (r_s1_vld) begin
                if (r_s1_last) begin
                    r_max     <= '0;
                    r_max_idx <= '0;
                    r_total   <= '0;
                    r_cnt     <= '0;
                end else begin
                    r_max     <= n_max;
                    r_max_idx <= n_max_idx;
                    r_total   <= n_total;
                    r_cnt     <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s2_max   <= n_max;
            r_s2_idx   <= n_max_idx;
            r_s2_total <= n_total;
            r_s2_cnt   <= n_cnt;
        end
    end

    // Stage 3: noise sum and the two simple tests.
    logic              r_s3_vld;
    logic [PWR_W-1:0]  r_s3_max;
    logic [PEAK_W-1:0] r_s3_idx;
    logic [TOT_W-1:0]  r_s3_noise;
    logic [CNT_W-1:0]  r_s3_cm1;
    logic              r_s3_few;
    logic              r_s3_weak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s3_max   <= r_s2_max;
            r_s3_idx   <= r_s2_idx;
            r_s3_noise <= r_s2_total - TOT_W'(r_s2_max);
            r_s3_cm1   <= r_s2_cnt - CNT_W'(1);
            r_s3_few   <= r_s2_cnt <= CNT_W'(1);
            r_s3_weak  <= r_s2_max < r_pwr_thr;
        end
    end

    // Stage 4: both sides of the ratio test.
    logic              r_s4_vld;
    logic [PWR_W-1:0]  r_s4_max;
    logic [PEAK_W-1:0] r_s4_idx;
    logic [TOT_W-1:0]  r_s4_noise;
    logic              r_s4_few;
    logic              r_s4_weak;
    logic [LHS_W-1:0]  r_s4_lhs;
    logic [RHS_W-1:0]  r_s4_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s4_max   <= r_s3_max;
            r_s4_idx   <= r_s3_idx;
            r_s4_noise <= r_s3_noise;
            r_s4_few   <= r_s3_few;
            r_s4_weak  <= r_s3_weak;
            r_s4_lhs   <= LHS_W'(r_s3_max) * LHS_W'(r_s3_cm1);
            r_s4_rhs   <= RHS_W'(r_s3_noise) * RHS_W'(r_ratio);
        end
    end

    // Stage 5: status decision and result register.
    logic [CMP_W-1:0]  lhs_x;
    logic [CMP_W-1:0]  rhs_x;
    spng_pkg::t_status n_status;

    always_comb begin
        lhs_x = CMP_W'(r_s4_lhs) << 8;
        rhs_x = CMP_W'(r_s4_rhs);
        priority if (r_s4_few) begin
            n_status = spng_pkg::ST_TOO_FEW;
        end else if (r_s4_weak) begin
            n_status = spng_pkg::ST_BELOW_THR;
        end else if (lhs_x < rhs_x) begin
            n_status = spng_pkg::ST_RATIO_LOW;
        end else begin
            n_status = spng_pkg::ST_DETECTED;
        end
    end

    logic [spng_pkg::OUT_TDATA_W-1:0] r_out_data;
    spng_pkg::t_status                r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_s4_vld) begin
            r_out_data   <= {PAD_W'(0), r_s4_noise, r_s4_max, r_s4_idx};
            r_out_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

endmodule

FILE: rtl/spng_checker.sv
// Port-level checks for the spectral peak noise gate, bound to the top level.
// Depends on spng_pkg and spectral_peak_noise_gate_unit.
module spng_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [spng_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [spng_pkg::STATUS_W-1:0]    o_m_axis_tuser
);

    localparam int PWR_LO = spng_pkg::PEAK_W;
    localparam int PWR_HI = spng_pkg::PEAK_W + spng_pkg::PWR_W - 1;
    localparam int NS_LO  = PWR_HI + 1;
    localparam int NS_HI  = PWR_HI + spng_pkg::TOT_W;

    // A result word waiting to be taken holds steady.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    // The input side is held back only by a stalled result.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a pending result");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A zero peak power can only come with peak bin zero.
    a_zero_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[PWR_HI:PWR_LO] == '0) |->
            o_m_axis_tdata[spng_pkg::PEAK_W-1:0] == '0)
        else $error("nonzero peak bin with zero peak power");

    // With no noise the ratio test cannot fail.
    a_no_noise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[NS_HI:NS_LO] == '0) |->
            o_m_axis_tuser != spng_pkg::ST_RATIO_LOW)
        else $error("ratio failure reported with zero noise sum");

endmodule

bind spectral_peak_noise_gate_unit spng_checker u_spng_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
